### sv/assert_macros.svh
// assertion macros used by the node unit rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition");

`endif

### sv/rama_pkg.sv
// package for the distributed lock node: sizes, codes and payload structs
// no dependencies
package rama_pkg;

	localparam int MAX_NODES  = 16;
	localparam int CLOCK_BITS = 32;
	localparam int ID_LIMIT   = (MAX_NODES < 16) ? MAX_NODES : 16;
	localparam int DEFER_CAP  = ID_LIMIT - 1;

	localparam int ID_W       = 4;
	localparam int CNT_W      = 5;
	localparam int STAMP_W    = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [1:0] OP_LOCK    = 2'd0;
	localparam logic [1:0] OP_REQUEST = 2'd1;
	localparam logic [1:0] OP_REPLY   = 2'd2;
	localparam logic [1:0] OP_UNLOCK  = 2'd3;

	localparam logic [1:0] KIND_REQUEST = 2'd0;
	localparam logic [1:0] KIND_REPLY   = 2'd1;
	localparam logic [1:0] KIND_GRANT   = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SELF_ID    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [ID_W-1:0]    peer_id;
		logic [STAMP_W-1:0] peer_stamp;
	} in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [ID_W-1:0]    dest_node;
		logic [STAMP_W-1:0] stamp;
		logic               last;
	} out_t;

	typedef struct packed {
		logic            push;
		logic [ID_W-1:0] push_id;
		logic            pop;
	} stack_ctl_t;

endpackage

### sv/rama_defer_stack.sv
// last-in first-out store of deferred requester ids
// depends on rama_pkg
module rama_defer_stack
	import rama_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  stack_ctl_t       ctl,
	output logic [ID_W-1:0]  rd_id,
	output logic [CNT_W-1:0] count
);

	logic [ID_W-1:0]  mem [ID_LIMIT];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] top_c;
	logic [ID_W-1:0]  rd_id_q;

	assign top_c = count_q - 1'b1;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[count_q[ID_W-1:0]] <= ctl.push_id;
		end
		if (ctl.pop) begin
			rd_id_q <= mem[top_c[ID_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.pop) begin
			count_q <= top_c;
		end
	end

	assign rd_id = rd_id_q;
	assign count = count_q;

endmodule

### sv/ricart_agrawala_mutex_node_unit.sv
// One node of a distributed mutual-exclusion lock, fed one event per transaction:
// lock, received request, received reply, unlock. For a lock the sequencer walks node
// ids one per cycle while the output is not stalled and emits one request per peer.
// An unlock emits one reply per deferred node, each reply waiting on a read of the
// deferral stack. Every other event has its decision made by one clock comparator
// after the event is registered. in_stall stays high until the last result of the
// current event is in the output register; output stalls lengthen each event that
// emits a result.
// depends on rama_pkg, rama_defer_stack and assert_macros.svh
`include "assert_macros.svh"

module ricart_agrawala_mutex_node_unit
	import rama_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_ONE  = 3'd2;
	localparam logic [2:0] S_LOCK = 3'd3;
	localparam logic [2:0] S_URD  = 3'd4;
	localparam logic [2:0] S_UEM  = 3'd5;

	logic [2:0]            state_q;
	logic [ID_W-1:0]       self_q;
	logic [CNT_W-1:0]      node_count_q;
	logic                  crit_q;
	logic                  req_q;
	logic [CLOCK_BITS-1:0] clock_q;
	logic [CNT_W-1:0]      replies_q;
	logic [ID_W-1:0]       id_q;
	logic [CNT_W-1:0]      sent_q;
	logic [1:0]            res_kind_q;
	logic [ID_W-1:0]       res_dest_q;

	logic [1:0]            op_q;
	logic [ID_W-1:0]       peer_q;
	logic [CLOCK_BITS-1:0] pstamp_q;

	logic                  out_valid_q;
	out_t                  out_q;

	logic                  in_acc;
	logic                  slot_free;
	logic [CNT_W-1:0]      n_m1;
	logic                  clk_lt;
	logic                  clk_eq;
	logic                  defer;
	logic [CLOCK_BITS-1:0] clock_inc;
	logic [CNT_W-1:0]      replies_nx;
	logic [CNT_W-1:0]      sent_nx;
	logic                  lock_last;

	logic                  emit;
	out_t                  emit_data;

	stack_ctl_t            stk_ctl;
	logic [ID_W-1:0]       stk_rd_id;
	logic [CNT_W-1:0]      stk_count;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		if (node_count_q == '0) begin
			n_m1 = '0;
		end else if (node_count_q > CNT_W'(ID_LIMIT)) begin
			n_m1 = CNT_W'(ID_LIMIT - 1);
		end else begin
			n_m1 = node_count_q - 1'b1;
		end
	end

	// shared clock comparator
	assign clk_lt     = clock_q < pstamp_q;
	assign clk_eq     = clock_q == pstamp_q;
	assign defer      = crit_q || (req_q && (clk_lt || (clk_eq && self_q < peer_q)));
	assign clock_inc  = clock_q + 1'b1;
	assign replies_nx = replies_q + 1'b1;
	assign sent_nx    = sent_q + 1'b1;
	assign lock_last  = (sent_nx == n_m1);

	always_comb begin
		stk_ctl.push    = (state_q == S_EVAL) && (op_q == OP_REQUEST) && defer
			&& (stk_count < CNT_W'(DEFER_CAP));
		stk_ctl.push_id = peer_q;
		stk_ctl.pop     = (state_q == S_URD);
	end

	rama_defer_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (stk_ctl),
		.rd_id  (stk_rd_id),
		.count  (stk_count)
	);

	always_comb begin
		emit                = 1'b0;
		emit_data.kind      = res_kind_q;
		emit_data.dest_node = res_dest_q;
		emit_data.stamp     = STAMP_W'(clock_q);
		emit_data.last      = 1'b1;
		case (state_q)
			S_ONE: begin
				emit = slot_free;
			end
			S_LOCK: begin
				emit                = slot_free && (id_q != self_q);
				emit_data.kind      = KIND_REQUEST;
				emit_data.dest_node = id_q;
				emit_data.last      = lock_last;
			end
			S_UEM: begin
				emit                = slot_free;
				emit_data.kind      = KIND_REPLY;
				emit_data.dest_node = stk_rd_id;
				emit_data.last      = (stk_count == '0);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q     <= in_data.opcode;
			peer_q   <= in_data.peer_id;
			pstamp_q <= CLOCK_BITS'(in_data.peer_stamp);
		end
		if (emit) begin
			out_q <= emit_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			self_q       <= '0;
			node_count_q <= CNT_W'(16);
			crit_q       <= 1'b0;
			req_q        <= 1'b0;
			clock_q      <= '0;
			replies_q    <= '0;
			id_q         <= '0;
			sent_q       <= '0;
			res_kind_q   <= KIND_ERROR;
			res_dest_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SELF_ID: self_q <= cfg_data[ID_W-1:0];
					REG_NODE_COUNT: node_count_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					res_dest_q <= (op_q == OP_REQUEST && !defer) ? peer_q : '0;
					case (op_q)
						OP_LOCK: begin
							if (req_q || crit_q) begin
								res_kind_q <= KIND_ERROR;
								state_q    <= S_ONE;
							end else if (n_m1 == '0) begin
								crit_q     <= 1'b1;
								replies_q  <= '0;
								clock_q    <= clock_inc;
								res_kind_q <= KIND_GRANT;
								state_q    <= S_ONE;
							end else begin
								req_q     <= 1'b1;
								replies_q <= '0;
								id_q      <= '0;
								sent_q    <= '0;
								state_q   <= S_LOCK;
							end
						end
						OP_REQUEST: begin
							if (defer) begin
								if (stk_count >= CNT_W'(DEFER_CAP)) begin
									res_kind_q <= KIND_ERROR;
									state_q    <= S_ONE;
								end else begin
									state_q <= S_IDLE;
								end
							end else begin
								if (!req_q && clk_lt) begin
									clock_q <= pstamp_q;
								end
								res_kind_q <= KIND_REPLY;
								state_q    <= S_ONE;
							end
						end
						OP_REPLY: begin
							if (!req_q) begin
								state_q <= S_IDLE;
							end else if (replies_nx >= n_m1) begin
								req_q      <= 1'b0;
								crit_q     <= 1'b1;
								replies_q  <= '0;
								clock_q    <= clock_inc;
								res_kind_q <= KIND_GRANT;
								state_q    <= S_ONE;
							end else begin
								replies_q <= replies_nx;
								state_q   <= S_IDLE;
							end
						end
						default: begin
							if (!crit_q) begin
								res_kind_q <= KIND_ERROR;
								state_q    <= S_ONE;
							end else begin
								crit_q  <= 1'b0;
								clock_q <= clock_inc;
								state_q <= (stk_count == '0) ? S_IDLE : S_URD;
							end
						end
					endcase
				end
				S_ONE: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				S_LOCK: begin
					if (id_q == self_q) begin
						id_q <= id_q + 1'b1;
					end else if (emit) begin
						id_q   <= id_q + 1'b1;
						sent_q <= sent_nx;
						if (lock_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_URD: begin
					state_q <= S_UEM;
				end
				S_UEM: begin
					if (emit) begin
						state_q <= (stk_count == '0) ? S_IDLE : S_URD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEVER(a_crit_and_req, crit_q && req_q)
	`ASSERT_CLK(a_replies_idle, !req_q |-> (replies_q == '0))
	`ASSERT_CLK(a_busy_after_accept, in_acc |=> in_stall)
	`ASSERT_CLK(a_defer_cap, stk_count <= CNT_W'(DEFER_CAP))
	`ASSERT_NEVER(a_pop_empty, stk_ctl.pop && (stk_count == '0))

endmodule

### verif/ricart_agrawala_mutex_node_unit_test.sv
`timescale 1ns / 100ps
// self-checking bench for ricart_agrawala_mutex_node_unit: directed event table, then random
// lock/request/reply/unlock traffic checked against a behavioral node model
// depends on rama_pkg and the ricart_agrawala_mutex_node_unit rtl
module ricart_agrawala_mutex_node_unit_test;
	import rama_pkg::*;

	typedef enum {ROW_PREDICT, ROW_SILENT, ROW_TYPED, ROW_CONFIG} row_e;

	typedef struct {
		row_e       how;
		in_t        ev;
		out_t       msg;
		logic [4:0] self_v;
		logic [4:0] count_v;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// node model state
	logic [3:0]  node_self = 4'd0;
	logic [4:0]  node_total = 5'd16;
	logic        crit_held = 1'b0;
	logic        lock_wanted = 1'b0;
	logic [31:0] lclock = 32'd0;
	int          reply_tally = 0;
	logic [3:0]  parked_ids [0:15];
	int          parked_cnt = 0;

	out_t event_msgs[$];
	out_t owed_messages[$];
	row_t script[$];

	int  mismatches = 0;
	int  quiet_cycles = 0;
	int  stall_left = 0;
	int  next_gap = 1;
	int  flood_left = 0;
	bit  holding = 1'b0;
	bit  calm = 1'b0;

	ricart_agrawala_mutex_node_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic void add_msg(logic [1:0] kind, logic [3:0] dest);
		out_t m;
		m.kind = kind;
		m.dest_node = dest;
		m.stamp = lclock;
		m.last = 1'b0;
		event_msgs.push_back(m);
	endfunction

	function automatic void grant_section();
		lock_wanted = 1'b0;
		crit_held = 1'b1;
		reply_tally = 0;
		lclock = lclock + 32'd1;
		add_msg(KIND_GRANT, 4'd0);
	endfunction

	function automatic void predict_node_event(in_t ev);
		int  n;
		bit  defer;
		event_msgs.delete();
		n = int'(node_total);
		if (n < 1) n = 1;
		if (n > ID_LIMIT) n = ID_LIMIT;
		case (ev.opcode)
			OP_LOCK: begin
				if (lock_wanted || crit_held) begin
					add_msg(KIND_ERROR, 4'd0);
				end else if (n == 1) begin
					grant_section();
				end else begin
					lock_wanted = 1'b1;
					reply_tally = 0;
					for (int id = 0; id < 16; id++) begin
						if (event_msgs.size() < n - 1 && id != node_self)
							add_msg(KIND_REQUEST, id[3:0]);
					end
				end
			end
			OP_REQUEST: begin
				defer = crit_held;
				if (!defer && lock_wanted)
					defer = (lclock < ev.peer_stamp) ||
						(lclock == ev.peer_stamp && node_self < ev.peer_id);
				if (defer) begin
					if (parked_cnt >= DEFER_CAP) begin
						add_msg(KIND_ERROR, 4'd0);
					end else begin
						parked_ids[parked_cnt[3:0]] = ev.peer_id;
						parked_cnt++;
					end
				end else begin
					if (!lock_wanted && ev.peer_stamp > lclock) lclock = ev.peer_stamp;
					add_msg(KIND_REPLY, ev.peer_id);
				end
			end
			OP_REPLY: begin
				if (lock_wanted) begin
					reply_tally++;
					if (reply_tally >= n - 1) grant_section();
				end
			end
			default: begin
				if (!crit_held) begin
					add_msg(KIND_ERROR, 4'd0);
				end else begin
					crit_held = 1'b0;
					lclock = lclock + 32'd1;
					while (parked_cnt > 0 && event_msgs.size() < 15) begin
						parked_cnt--;
						add_msg(KIND_REPLY, parked_ids[parked_cnt[3:0]]);
					end
				end
			end
		endcase
		if (event_msgs.size() > 0) event_msgs[event_msgs.size() - 1].last = 1'b1;
	endfunction

	function automatic void add_row(row_e how, logic [1:0] op, logic [3:0] peer,
			logic [31:0] pstamp, logic [1:0] kind, logic [3:0] dest, logic [31:0] mstamp);
		row_t r;
		r.how = how;
		r.ev.opcode = op;
		r.ev.peer_id = peer;
		r.ev.peer_stamp = pstamp;
		r.msg.kind = kind;
		r.msg.dest_node = dest;
		r.msg.stamp = mstamp;
		r.msg.last = 1'b1;
		r.self_v = '0;
		r.count_v = '0;
		script.push_back(r);
	endfunction

	function automatic void add_cfg(logic [4:0] self_v, logic [4:0] count_v);
		row_t r;
		r.how = ROW_CONFIG;
		r.ev = '0;
		r.msg = '0;
		r.self_v = self_v;
		r.count_v = count_v;
		script.push_back(r);
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic in_t pick_event();
		in_t ev;
		int  r;
		ev.opcode = OP_LOCK;
		ev.peer_id = 4'($urandom_range(0, 15));
		ev.peer_stamp = $urandom;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			ev.opcode = 2'($urandom_range(0, 3));
			return ev;
		end
		if (flood_left > 0) begin
			flood_left--;
			ev.opcode = OP_REQUEST;
		end else if (crit_held) begin
			if ($urandom_range(0, 19) == 0) flood_left = 16;
			ev.opcode = (r < 45 || flood_left > 0) ? OP_REQUEST : OP_UNLOCK;
		end else if (lock_wanted) begin
			ev.opcode = (r < 70) ? OP_REPLY : OP_REQUEST;
		end else begin
			ev.opcode = (r < 55) ? OP_LOCK : OP_REQUEST;
		end
		if (ev.opcode == OP_REQUEST) begin
			r = $urandom_range(0, 9);
			// stamps near the local clock make ties and near misses common
			if (r < 5) ev.peer_stamp = lclock + $urandom_range(0, 4) - 2;
			else if (r == 5) ev.peer_stamp = 32'hFFFF_FFFF - $urandom_range(0, 3);
			if ($urandom_range(0, 7) == 0) ev.peer_id = node_self;
		end
		return ev;
	endfunction

	task automatic send_event(in_t ev, row_e how, out_t typed_msg);
		int gap;
		if (!holding) begin
			gap = next_gap;
			repeat (gap) @(posedge clk);
			in_valid <= 1'b1;
		end
		in_data <= ev;
		do @(posedge clk); while (in_stall);
		predict_node_event(ev);
		if (how == ROW_PREDICT) begin
			foreach (event_msgs[j]) owed_messages.push_back(event_msgs[j]);
		end else if (how == ROW_TYPED) begin
			owed_messages.push_back(typed_msg);
		end
		next_gap = pick_gap();
		holding = (next_gap == 0);
		if (!holding) in_valid <= 1'b0;
	endtask

	task automatic settle();
		if (holding) begin
			in_valid <= 1'b0;
			holding = 1'b0;
		end
		while (owed_messages.size() != 0) @(posedge clk);
		// events without a result may still be in flight
		repeat (40) @(posedge clk);
	endtask

	task automatic write_node_cfg(logic [4:0] self_v, logic [4:0] count_v);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SELF_ID;
		cfg_data <= self_v;
		do @(posedge clk); while (!cfg_ready);
		node_self = self_v[3:0];
		cfg_index <= REG_NODE_COUNT;
		cfg_data <= count_v;
		do @(posedge clk); while (!cfg_ready);
		node_total = count_v;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : result_side
		out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (owed_messages.size() == 0) begin
					$display("%0t: unexpected message kind=%0d dest=%0d stamp=%h last=%0d",
						$time, out_data.kind, out_data.dest_node, out_data.stamp,
						out_data.last);
					mismatches++;
				end else begin
					want = owed_messages.pop_front();
					if (out_data.kind !== want.kind || out_data.dest_node !== want.dest_node ||
							out_data.stamp !== want.stamp || out_data.last !== want.last) begin
						$display("%0t: expected kind=%0d dest=%0d stamp=%h last=%0d",
							$time, want.kind, want.dest_node, want.stamp, want.last);
						$display("%0t:   actual kind=%0d dest=%0d stamp=%h last=%0d",
							$time, out_data.kind, out_data.dest_node, out_data.stamp,
							out_data.last);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < 25) begin
				stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
					: $urandom_range(10, 40);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= 4000) begin
				$display("ricart_agrawala_mutex_node_unit regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int         i;
		logic [4:0] count_v;
		logic [4:0] count_edges [0:3];
		count_edges[0] = 5'd0;
		count_edges[1] = 5'd1;
		count_edges[2] = 5'd16;
		count_edges[3] = 5'd31;

		// reset settings: self 0 of 16 nodes
		add_row(ROW_TYPED, OP_UNLOCK, 0, 0, KIND_ERROR, 0, 32'd0);
		add_row(ROW_SILENT, OP_REPLY, 7, 32'h1234, 0, 0, 0);
		add_row(ROW_TYPED, OP_REQUEST, 15, 32'hFFFF_FFFF, KIND_REPLY, 15, 32'hFFFF_FFFF);
		add_row(ROW_PREDICT, OP_LOCK, 0, 0, 0, 0, 0);
		add_row(ROW_TYPED, OP_LOCK, 0, 0, KIND_ERROR, 0, 32'hFFFF_FFFF);
		add_row(ROW_SILENT, OP_REQUEST, 15, 32'hFFFF_FFFF, 0, 0, 0);
		add_row(ROW_TYPED, OP_REQUEST, 0, 32'hFFFF_FFFF, KIND_REPLY, 0, 32'hFFFF_FFFF);
		add_row(ROW_PREDICT, OP_REQUEST, 9, 32'd0, 0, 0, 0);
		// clock wraps at grant
		add_cfg(5'h1F, 5'd2);
		add_row(ROW_TYPED, OP_REPLY, 0, 0, KIND_GRANT, 0, 32'd0);
		add_row(ROW_SILENT, OP_REQUEST, 4, 32'd0, 0, 0, 0);
		add_row(ROW_PREDICT, OP_UNLOCK, 0, 0, 0, 0, 0);
		// lone node
		add_cfg(5'h00, 5'd0);
		add_row(ROW_TYPED, OP_LOCK, 0, 0, KIND_GRANT, 0, 32'd2);
		add_row(ROW_SILENT, OP_UNLOCK, 0, 0, 0, 0, 0);
		add_cfg(5'h13, 5'd31);
		add_row(ROW_PREDICT, OP_LOCK, 0, 0, 0, 0, 0);
		add_row(ROW_TYPED, OP_REQUEST, 3, 32'd3, KIND_REPLY, 3, 32'd3);
		// self id beyond node count
		add_cfg(5'h05, 5'd4);
		add_row(ROW_SILENT, OP_REPLY, 1, 32'd0, 0, 0, 0);
		add_row(ROW_SILENT, OP_REPLY, 1, 32'hFFFF_FFFF, 0, 0, 0);
		add_row(ROW_TYPED, OP_REPLY, 2, 0, KIND_GRANT, 0, 32'd4);
		add_row(ROW_SILENT, OP_UNLOCK, 0, 0, 0, 0, 0);
		add_row(ROW_PREDICT, OP_LOCK, 0, 0, 0, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < script.size(); i++) begin
			if (script[i].how == ROW_CONFIG) begin
				settle();
				write_node_cfg(script[i].self_v, script[i].count_v);
			end else begin
				send_event(script[i].ev, script[i].how, script[i].msg);
			end
		end

		for (i = 0; i < 280; i++) begin
			if (i % 40 == 0) begin
				settle();
				calm = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 2) == 0) count_v = count_edges[2'($urandom_range(0, 3))];
				else count_v = 5'($urandom_range(2, 6));
				write_node_cfg(5'($urandom_range(0, 31)), count_v);
			end
			send_event(pick_event(), ROW_PREDICT, '0);
		end

		settle();
		if (mismatches == 0) begin
			$display("ricart_agrawala_mutex_node_unit regression: pass");
		end else begin
			$display("ricart_agrawala_mutex_node_unit regression: fail");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/rama_pkg.sv
sv/rama_defer_stack.sv
sv/ricart_agrawala_mutex_node_unit.sv
verif/ricart_agrawala_mutex_node_unit_test.sv
